@@ hdl/alcf_pkg.sv @@
// package for the altitude complementary filter
// shared payload, command and status types, constants and saturation helper
// no dependencies
package alcf_pkg;

  localparam int DELAY_TAPS = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] GAIN_ACCEL_RST    = 24'd155344;
  localparam logic [23:0] GAIN_VELOCITY_RST = 24'd1398101;
  localparam logic [23:0] GAIN_POSITION_RST = 24'd4194304;
  localparam logic [15:0] CAL_SAMPLES_RST   = 16'd500;

  // ceil(2^36 / 125): exact floor(x / 125) for x below 2^29
  localparam logic [29:0] DT_RECIP = 30'd549755814;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_ACCEL    = 2'd0,
    REG_GAIN_VELOCITY = 2'd1,
    REG_GAIN_POSITION = 2'd2,
    REG_CAL_SAMPLES   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] baro_height;
    logic signed [31:0] vert_accel;
    logic [15:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] altitude;
    logic signed [31:0] vertical_speed;
    logic               calibrating;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL, ST_DT_M, ST_DT_W, ST_SC_M, ST_SC_W, ST_IN_M, ST_IN_W,
    ST_ACC, ST_DV_M, ST_DV_W, ST_DH_M, ST_DH_W, ST_UPD, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_DT, MS_SCALE, MS_INC, MS_DV, MS_DH
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAL, OP_DT, OP_SCALE, OP_INC, OP_ACC, OP_DV, OP_DH, OP_UPD, OP_OUT
  } op_t;

  typedef struct packed {
    logic       load_in;
    mul_sel_t   mul_sel;
    op_t        op;
    logic [1:0] corr_idx;
    logic       out_cal;
  } cmd_t;

  typedef struct packed {
    logic calib;
    logic out_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

@@ hdl/alcf_ctrl.sv @@
// sequencer for the altitude filter: walks one request through the shared multiplier
// depends on alcf_pkg
module alcf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  alcf_pkg::status_t status,
  output alcf_pkg::cmd_t   cmd
);
  import alcf_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       cal_r, cal_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
      cal_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cal_r   <= cal_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cal_nxt      = cal_r;
    cmd.load_in  = accept;
    cmd.mul_sel  = MS_DT;
    cmd.op       = OP_NONE;
    cmd.corr_idx = idx_r;
    cmd.out_cal  = cal_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cal_nxt   = status.calib;
          state_nxt = status.calib ? ST_CAL : ST_DT_M;
        end
      end
      ST_CAL: begin
        cmd.op    = OP_CAL;
        state_nxt = ST_OUT;
      end
      ST_DT_M: begin
        cmd.mul_sel = MS_DT;
        state_nxt   = ST_DT_W;
      end
      ST_DT_W: begin
        cmd.op    = OP_DT;
        idx_nxt   = 2'd0;
        state_nxt = ST_SC_M;
      end
      ST_SC_M: begin
        cmd.mul_sel = MS_SCALE;
        state_nxt   = ST_SC_W;
      end
      ST_SC_W: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_IN_M;
      end
      ST_IN_M: begin
        cmd.mul_sel = MS_INC;
        state_nxt   = ST_IN_W;
      end
      ST_IN_W: begin
        cmd.op = OP_INC;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_ACC;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_SC_M;
        end
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = ST_DV_M;
      end
      ST_DV_M: begin
        cmd.mul_sel = MS_DV;
        state_nxt   = ST_DV_W;
      end
      ST_DV_W: begin
        cmd.op    = OP_DV;
        state_nxt = ST_DH_M;
      end
      ST_DH_M: begin
        cmd.mul_sel = MS_DH;
        state_nxt   = ST_DH_W;
      end
      ST_DH_W: begin
        cmd.op    = OP_DH;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!status.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r != 2'd3)
    else $error("correction index out of range");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> !status.out_busy)
    else $error("result written while previous one pending");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_CAL || state_r == ST_DT_M))
    else $error("accepted request did not start processing");
endmodule

@@ hdl/alcf_dp.sv @@
// datapath for the altitude filter: registers, config, shared multiplier, result register
// depends on alcf_pkg
module alcf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alcf_pkg::cmd_t                cmd,
  output alcf_pkg::status_t             status,
  input  alcf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output alcf_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [alcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alcf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alcf_pkg::*;

  logic [23:0] gain_r [3];
  logic [15:0] cal_samples_r;

  in_item_t           in_r;
  logic signed [31:0] hist_r [DELAY_TAPS+1];
  logic signed [31:0] raw_height_r, raw_speed_r, prev_accel_r, curr_accel_r;
  logic signed [31:0] corr_r [3];
  logic signed [31:0] ground_r, speed_out_r, height_out_r;
  logic [15:0]        count_r;
  logic [22:0]        dt_r;
  logic signed [33:0] err_r;
  logic signed [31:0] scaled_r, dv_r;
  logic signed [65:0] prod_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic signed [34:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [65:0] sum_w;
  logic signed [31:0] inc_w;

  assign status.calib    = (count_r < cal_samples_r);
  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_DT: begin
        mul_a = {6'd0, in_r.elapsed_us, 13'd0};
        mul_b = {1'b0, DT_RECIP};
      end
      MS_SCALE: begin
        mul_a = 35'(err_r);
        mul_b = {7'd0, gain_r[cmd.corr_idx]};
      end
      MS_INC: begin
        mul_a = 35'(scaled_r);
        mul_b = {8'd0, dt_r};
      end
      MS_DV: begin
        mul_a = 35'(33'(prev_accel_r) + 33'(curr_accel_r));
        mul_b = {8'd0, dt_r};
      end
      MS_DH: begin
        mul_a = 35'((34'(speed_out_r) <<< 1) + 34'(dv_r));
        mul_b = {8'd0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign inc_w = sat32(prod_r >>> 16);
  assign sum_w = 66'(corr_r[cmd.corr_idx]) + 66'(inc_w);

  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    case (cmd.op)
      OP_DT: begin
        dt_r  <= prod_r[58:36];
        err_r <= (34'(in_r.baro_height) - 34'(ground_r)) - 34'(hist_r[DELAY_TAPS]);
      end
      OP_SCALE: scaled_r <= sat32(prod_r >>> 22);
      OP_DV:    dv_r <= sat32(prod_r >>> 17);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[0]     <= GAIN_ACCEL_RST;
      gain_r[1]     <= GAIN_VELOCITY_RST;
      gain_r[2]     <= GAIN_POSITION_RST;
      cal_samples_r <= CAL_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_ACCEL:    gain_r[0] <= cfg_wdata;
        REG_GAIN_VELOCITY: gain_r[1] <= cfg_wdata;
        REG_GAIN_POSITION: gain_r[2] <= cfg_wdata;
        REG_CAL_SAMPLES:   cal_samples_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DELAY_TAPS; k++) begin
        hist_r[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        corr_r[k] <= '0;
      end
      raw_height_r <= '0;
      raw_speed_r  <= '0;
      prev_accel_r <= '0;
      curr_accel_r <= '0;
      ground_r     <= '0;
      speed_out_r  <= '0;
      height_out_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CAL: begin
          for (int k = 0; k < 3; k++) begin
            corr_r[k] <= '0;
          end
          ground_r <= in_r.baro_height;
          count_r  <= count_r + 16'd1;
        end
        OP_INC: corr_r[cmd.corr_idx] <= sat32(sum_w);
        OP_ACC: begin
          prev_accel_r <= curr_accel_r;
          curr_accel_r <= sat32(66'(in_r.vert_accel) + 66'(corr_r[0]));
        end
        OP_DV: raw_speed_r <= sat32(66'(raw_speed_r) + 66'(sat32(prod_r >>> 17)));
        OP_DH: raw_height_r <= sat32(66'(raw_height_r) + 66'(sat32(prod_r >>> 17)));
        OP_UPD: begin
          height_out_r <= sat32(66'(raw_height_r) + 66'(corr_r[2]));
          speed_out_r  <= sat32(66'(raw_speed_r) + 66'(corr_r[1]));
          for (int k = DELAY_TAPS; k > 0; k--) begin
            hist_r[k] <= hist_r[k-1];
          end
          hist_r[0] <= sat32(66'(raw_height_r) + 66'(corr_r[2]));
        end
        OP_OUT: begin
          out_r.altitude       <= height_out_r;
          out_r.vertical_speed <= speed_out_r;
          out_r.calibrating    <= cmd.out_cal;
        end
        default: ;
      endcase
    end
  end

  a_cal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CAL) |=> (corr_r[0] == 32'sd0 && corr_r[1] == 32'sd0 && corr_r[2] == 32'sd0))
    else $error("corrections not cleared during calibration");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> out_valid_r)
    else $error("result register not loaded");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CAL) |=> (count_r == $past(count_r) + 16'd1))
    else $error("sample count did not advance");
endmodule

@@ hdl/altitude_complementary_filter.sv @@
// altitude complementary filter: one request in, one result out; the next request is
// taken only once the result is loaded, as nine multiplies run in sequence through
// one shared 35x31 multiplier while tracking (none while calibrating).
// synchronous active-low reset restores default gains and clears all filter state
// top level: joins alcf_ctrl and alcf_dp; depends on alcf_pkg
module altitude_complementary_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  alcf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output alcf_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [alcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alcf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alcf_pkg::*;

  cmd_t    cmd;
  status_t status;

  alcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  alcf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );
endmodule

@@ verif/altitude_complementary_filter_test.sv @@
// self-checking testbench for altitude_complementary_filter
// predicts every result from its own fixed-point filter model; depends on alcf_pkg
module altitude_complementary_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import alcf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  altitude_complementary_filter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state mirror
  logic [23:0] k_accel, k_vel, k_pos;
  logic [15:0] cal_limit, cal_count;
  logic signed [31:0] hist [DELAY_TAPS+1];
  logic signed [31:0] h_raw, v_raw, a_prev, a_curr, c_acc, c_vel, c_pos, g_offset;
  logic signed [31:0] v_est, h_est;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int n_queued = 0, n_accepted = 0, n_errors = 0;
  bit in_taken;
  int hold_left = 0;
  bit held_once = 0;

  function automatic logic signed [31:0] clip(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] corr_update(logic signed [31:0] c, longint e,
                                                     logic [23:0] g, longint dt);
    longint scaled;
    scaled = clip((e * longint'(g)) >>> 22);
    return clip(longint'(c) + longint'(clip((scaled * dt) >>> 16)));
  endfunction

  task automatic predict_result(in_item_t it);
    longint dt, e, dv, dh;
    out_item_t r;
    dt = (longint'(it.elapsed_us) << 16) / 1000;
    if (cal_count < cal_limit) begin
      c_acc = 0; c_vel = 0; c_pos = 0;
      g_offset = it.baro_height;
      cal_count++;
      r.calibrating = 1'b1;
    end else begin
      e = longint'(it.baro_height) - longint'(g_offset) - longint'(hist[DELAY_TAPS]);
      c_acc = corr_update(c_acc, e, k_accel, dt);
      c_vel = corr_update(c_vel, e, k_vel, dt);
      c_pos = corr_update(c_pos, e, k_pos, dt);
      a_prev = a_curr;
      a_curr = clip(longint'(it.vert_accel) + longint'(c_acc));
      dv = clip(((longint'(a_prev) + longint'(a_curr)) * dt) >>> 17);
      dh = clip(((2 * longint'(v_est) + dv) * dt) >>> 17);
      h_raw = clip(longint'(h_raw) + dh);
      h_est = clip(longint'(h_raw) + longint'(c_pos));
      v_raw = clip(longint'(v_raw) + dv);
      v_est = clip(longint'(v_raw) + longint'(c_vel));
      for (int k = DELAY_TAPS; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = h_est;
      r.calibrating = 1'b0;
    end
    r.altitude = h_est;
    r.vertical_speed = v_est;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic bit quiet();
    return n_accepted >= 200 && n_accepted < 350;
  endfunction

  // accept side and checker, sampled at the rising edge
  always @(posedge clk) begin
    out_item_t w;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      n_accepted++;
      predict_result(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, altitude", out_data.altitude, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_data.altitude !== w.altitude)
          report_mismatch("altitude", out_data.altitude, w.altitude);
        if (out_data.vertical_speed !== w.vertical_speed)
          report_mismatch("vertical_speed", out_data.vertical_speed, w.vertical_speed);
        if (out_data.calibrating !== w.calibrating)
          report_mismatch("calibrating", out_data.calibrating, w.calibrating);
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_requests.size() > 0 && (quiet() || $urandom_range(0, 99) >= 10)) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (!held_once && n_accepted >= 600) begin
      held_once = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet() && $urandom_range(0, 99) < 10;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_ACCEL:    k_accel = value;
      REG_GAIN_VELOCITY: k_vel = value;
      REG_GAIN_POSITION: k_pos = value;
      REG_CAL_SAMPLES:   cal_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_gains(logic [23:0] ga, logic [23:0] gv, logic [23:0] gp);
    write_reg(REG_GAIN_ACCEL, ga);
    write_reg(REG_GAIN_VELOCITY, gv);
    write_reg(REG_GAIN_POSITION, gp);
  endtask

  task automatic queue_request(logic signed [31:0] b, logic signed [31:0] a, logic [15:0] us);
    in_item_t it;
    it.baro_height = b;
    it.vert_accel = a;
    it.elapsed_us = us;
    pending_requests.push_back(it);
    n_queued++;
  endtask

  task automatic queue_random();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7)
      // plausible flight: height and accel near zero, millisecond steps
      queue_request(int'($urandom_range(0, 4000000)) - 2000000,
                    int'($urandom_range(0, 400000)) - 200000,
                    16'($urandom_range(1000, 20000)));
    else if (mode == 7)
      queue_request($urandom, $urandom, 16'($urandom));
    else if (mode == 8)
      queue_request($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000,
                    $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000,
                    $urandom_range(0, 1) ? 16'hffff : 16'h0000);
    else
      queue_request(int'($urandom_range(0, 200000)) - 100000, $urandom, 16'd0);
  endtask

  task automatic wait_idle();
    wait (n_accepted == n_queued && expected_results.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    k_accel = GAIN_ACCEL_RST;
    k_vel = GAIN_VELOCITY_RST;
    k_pos = GAIN_POSITION_RST;
    cal_limit = CAL_SAMPLES_RST;
    cal_count = 0;
    foreach (hist[k]) hist[k] = 0;
    {h_raw, v_raw, a_prev, a_curr, c_acc, c_vel, c_pos, g_offset, v_est, h_est} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: short calibration, then field extremes with default gains
    write_reg(REG_CAL_SAMPLES, 24'd4);
    queue_request(32'sh00010000, 0, 16'd1000);
    queue_request(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    queue_request(32'sh80000000, 32'sh80000000, 16'd0);
    queue_request(32'sh00640000, 0, 16'd5000);
    queue_request(32'sh00650000, 32'sh00010000, 16'd5000);
    queue_request(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    queue_request(32'sh80000000, 32'sh80000000, 16'hffff);
    queue_request(32'sh80000000, 32'sh7fffffff, 16'hffff);
    queue_request(32'sh00640000, 0, 16'd0);
    queue_request(32'sh00700000, 32'shfff00000, 16'd0);
    queue_request(32'sh00600000, 32'sh00100000, 16'd1);
    queue_request(32'sh00640000, 0, 16'd999);
    queue_request(32'shffffffff, 32'shffffffff, 16'd2000);
    queue_request(0, 0, 16'd10000);
    wait_idle();

    for (int phase = 1; phase <= 7; phase++) begin
      int n_items;
      n_items = 150;
      case (phase)
        1: begin
          write_gains(24'hffffff, 24'hffffff, 24'hffffff);
          write_reg(REG_CAL_SAMPLES, 24'd0);
        end
        2: write_gains(24'h0, 24'h0, 24'h0);
        3: begin
          // raised count resumes calibration
          write_gains(24'($urandom), 24'($urandom), 24'($urandom));
          write_reg(REG_CAL_SAMPLES, 24'(cal_count + 16'd6));
        end
        4: begin
          write_reg(REG_CAL_SAMPLES, 24'hffff);
          n_items = 40;
        end
        5: begin
          write_gains(GAIN_ACCEL_RST, GAIN_VELOCITY_RST, GAIN_POSITION_RST);
          write_reg(REG_CAL_SAMPLES, 24'd0);
        end
        default: begin
          write_gains(24'($urandom_range(0, 1 << 23)), 24'($urandom_range(0, 1 << 23)),
                      24'($urandom_range(0, 1 << 23)));
          write_reg(REG_CAL_SAMPLES, 24'(cal_count + 16'($urandom_range(0, 10))));
        end
      endcase
      repeat (n_items) queue_random();
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("** altitude_complementary_filter: PASSED **");
    end else begin
      $display("** altitude_complementary_filter: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** altitude_complementary_filter: FAILED **");
    $finish;
  end

endmodule
